@@ rtl/linear_prime_sieve_defines.svh @@
// Assertion macros used by the checker file of the prime sieve.
`ifndef LINEAR_PRIME_SIEVE_DEFINES_SVH
`define LINEAR_PRIME_SIEVE_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define LPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define LPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays armed through reset.
`define LPS_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lps_pkg.sv @@
// Package of the prime sieve: sizes, microcode types and the microcode table.
package lps_pkg;

    // Sizes of the sieve and of its stores.
    localparam int MAX_LIMIT   = 65536;
    localparam int PRIME_SLOTS = 8192;
    localparam int FIELD_W     = 17;
    localparam int FIRST_CAND  = 2;
    localparam int MAP_DEPTH   = MAX_LIMIT + 1;
    localparam int MAP_AW      = $clog2(MAP_DEPTH);
    localparam int SLOT_AW     = $clog2(PRIME_SLOTS);
    localparam int TOTAL_W     = $clog2(PRIME_SLOTS + 1);
    localparam int PROD_W      = 2 * FIELD_W;
    localparam int DIV_STEPS   = FIELD_W;
    localparam int DIV_CW      = $clog2(DIV_STEPS + 1);
    localparam int STEP_W      = 4;

    // Microcode step addresses.
    typedef enum logic [STEP_W-1:0] {
        S_CLEAR,
        S_WAIT,
        S_CHECK,
        S_FETCH,
        S_MUL,
        S_TEST,
        S_MARK,
        S_DIVW,
        S_NEXT,
        S_LOOP,
        S_EMIT,
        S_HOLD
    } step_t;

    // Jump conditions; a step jumps when its condition holds, else it falls through.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_CLR_LAST,
        C_NO_REQ,
        C_SEQ_ERR,
        C_WALK_END,
        C_PROD_GT,
        C_DIV_BUSY,
        C_REM_ZERO,
        C_OUT_FREE
    } cond_t;

    // Datapath actions of one control word.
    typedef struct packed {
        logic clear;
        logic take;
        logic check;
        logic fetch;
        logic mul;
        logic mark;
        logic advance;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        cond_t cond;
        step_t target;
        ctrl_t ctrl;
    } uword_t;

    // Datapath flags tested by the sequencer.
    typedef struct packed {
        logic clr_last;
        logic req;
        logic seq_err;
        logic walk_end;
        logic prod_gt;
        logic div_busy;
        logic rem_zero;
        logic out_free;
    } dp_status_t;

    // The microprogram: one control word for each step.
    function automatic uword_t ucode_rom(input step_t s);
        uword_t w;
        w = '0;
        case (s)
            S_CLEAR:
            begin
                w.cond       = C_NOT_CLR_LAST;
                w.target     = S_CLEAR;
                w.ctrl.clear = 1'b1;
            end
            S_WAIT:
            begin
                w.cond      = C_NO_REQ;
                w.target    = S_WAIT;
                w.ctrl.take = 1'b1;
            end
            S_CHECK:
            begin
                w.cond       = C_SEQ_ERR;
                w.target     = S_EMIT;
                w.ctrl.check = 1'b1;
            end
            S_FETCH:
            begin
                w.cond       = C_WALK_END;
                w.target     = S_EMIT;
                w.ctrl.fetch = 1'b1;
            end
            S_MUL:
            begin
                w.cond     = C_NEVER;
                w.target   = S_MUL;
                w.ctrl.mul = 1'b1;
            end
            S_TEST:
            begin
                w.cond   = C_PROD_GT;
                w.target = S_EMIT;
            end
            S_MARK:
            begin
                w.cond      = C_NEVER;
                w.target    = S_MARK;
                w.ctrl.mark = 1'b1;
            end
            S_DIVW:
            begin
                w.cond   = C_DIV_BUSY;
                w.target = S_DIVW;
            end
            S_NEXT:
            begin
                w.cond         = C_REM_ZERO;
                w.target       = S_EMIT;
                w.ctrl.advance = 1'b1;
            end
            S_LOOP:
            begin
                w.cond   = C_ALWAYS;
                w.target = S_FETCH;
            end
            S_EMIT:
            begin
                w.cond      = C_OUT_FREE;
                w.target    = S_WAIT;
                w.ctrl.emit = 1'b1;
            end
            S_HOLD:
            begin
                w.cond   = C_ALWAYS;
                w.target = S_EMIT;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = S_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/lps_if.sv @@
// Request and result channel interfaces of the prime sieve.
interface lps_in_if;
    import lps_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface lps_out_if;
    import lps_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] number;
    logic               prime_flag;
    logic               sequence_error;

    modport source (output valid, output number, output prime_flag,
                    output sequence_error, input ready);
    modport sink   (input valid, input number, input prime_flag,
                    input sequence_error, output ready);
endinterface

@@ rtl/linear_prime_sieve.sv @@
// Linear prime sieve: classifies consecutive integers from two and marks their multiples.
//
// Requests on cand_ch carry the next candidate (2, 3, 4, ...); each gives one result
// on result_ch with the echoed number, a prime flag and a sequence error flag.
// A candidate that is out of order or above the limit is flagged and changes nothing.
// limit_we/limit_wdata write the limit register; write it only while the block is idle.
// After reset a clearing sweep zeroes the composite map, during which no request is
// taken; the limit resets to 65536 and the expected candidate to two.
// A flagged request goes straight to its result; otherwise the stored primes are walked
// in order. Each is fetched and multiplied by the candidate, and the walk stops where the
// product passes the limit; else the product is marked, the remainder unit (started with
// the multiply) is waited for, and the walk stops where the prime divides the candidate
// or at the end of the list. The next request is taken at the same edge at which the
// result can first be taken.
// One request is in work at a time. A finished result waits in the output register
// while the receiver stalls; the next request is still taken and worked on, and its
// result waits until the register is free, while the input stays stalled.
module linear_prime_sieve (
    input  logic                        clk,
    input  logic                        rst_n,
    lps_in_if.sink                      cand_ch,
    lps_out_if.source                   result_ch,
    input  logic                        limit_we,
    input  logic [lps_pkg::FIELD_W-1:0] limit_wdata
);
    import lps_pkg::*;

    ctrl_t      ctrl;
    dp_status_t status;

    // Microcode sequencer.
    lps_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // Datapath with the stores and the result register.
    lps_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .cand_ch     (cand_ch),
        .result_ch   (result_ch),
        .limit_we    (limit_we),
        .limit_wdata (limit_wdata)
    );

endmodule

@@ rtl/lps_div.sv @@
// Shift-and-subtract remainder unit, one quotient bit per cycle.
module lps_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lps_pkg::FIELD_W-1:0] dividend,
    input  logic [lps_pkg::FIELD_W-1:0] divisor,
    output logic                       busy,
    output logic                       rem_zero
);
    import lps_pkg::*;

    logic [DIV_CW-1:0]  cnt_reg, cnt_next;
    logic [FIELD_W-1:0] rem_reg, quo_reg, dvs_reg;
    logic [FIELD_W:0]   shifted;
    logic [FIELD_W:0]   diff;

    // Bring down the next dividend bit and subtract where it fits.
    assign shifted = {rem_reg, quo_reg[FIELD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // Step counter.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = DIV_CW'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - DIV_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Partial remainder and dividend shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= diff[FIELD_W] ? shifted[FIELD_W-1:0] : diff[FIELD_W-1:0];
            quo_reg <= {quo_reg[FIELD_W-2:0], 1'b0};
        end
    end

    assign busy     = (cnt_reg != '0);
    assign rem_zero = (rem_reg == '0);

endmodule

@@ rtl/lps_useq.sv @@
// Microcode sequencer: step counter, control word lookup and conditional jumps.
module lps_useq (
    input  logic                clk,
    input  logic                rst_n,
    input  lps_pkg::dp_status_t status,
    output lps_pkg::ctrl_t      ctrl
);
    import lps_pkg::*;

    step_t  step_reg, step_next;
    uword_t uw;
    logic   hit;

    // Control word of the current step.
    always_comb
    begin
        uw = ucode_rom(step_reg);
    end

    // Condition test and next step address.
    always_comb
    begin
        case (uw.cond)
            C_NEVER:        hit = 1'b0;
            C_ALWAYS:       hit = 1'b1;
            C_NOT_CLR_LAST: hit = !status.clr_last;
            C_NO_REQ:       hit = !status.req;
            C_SEQ_ERR:      hit = status.seq_err;
            C_WALK_END:     hit = status.walk_end;
            C_PROD_GT:      hit = status.prod_gt;
            C_DIV_BUSY:     hit = status.div_busy;
            C_REM_ZERO:     hit = status.rem_zero;
            C_OUT_FREE:     hit = status.out_free;
            default:        hit = 1'b1;
        endcase
        step_next = hit ? uw.target : step_t'(STEP_W'(step_reg) + STEP_W'(1));
    end

    // Actions driven into the datapath.
    always_comb
    begin
        ctrl = uw.ctrl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ rtl/lps_dpath.sv @@
// Sieve datapath: composite map, prime list, multiplier, remainder unit and result register.
module lps_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lps_pkg::ctrl_t              ctrl,
    output lps_pkg::dp_status_t         status,
    lps_in_if.sink                      cand_ch,
    lps_out_if.source                   result_ch,
    input  logic                        limit_we,
    input  logic [lps_pkg::FIELD_W-1:0] limit_wdata
);
    import lps_pkg::*;

    // Memories.
    logic map_mem  [MAP_DEPTH];
    logic [FIELD_W-1:0] list_mem [PRIME_SLOTS];

    // Control registers.
    logic [FIELD_W-1:0] limit_reg, limit_next;
    logic [FIELD_W-1:0] expected_reg, expected_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [MAP_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic               out_valid_reg, out_valid_next;

    // Working registers of the current request.
    logic [FIELD_W-1:0] cand_reg, lim_reg, list_rd_reg;
    logic               err_reg, prime_reg, map_rd_reg;
    logic [TOTAL_W-1:0] idx_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [FIELD_W-1:0] out_number_reg;
    logic               out_prime_reg, out_err_reg;

    logic               accept, err_in, list_we, map_we, map_wd, out_free;
    logic               div_busy, rem_zero;
    logic [FIELD_W-1:0] lim_eff;
    logic [MAP_AW-1:0]  map_wa;

    assign cand_ch.ready = ctrl.take;
    assign accept        = cand_ch.valid & ctrl.take;

    // Limit in effect and the sequence check of an incoming request.
    assign lim_eff = (limit_reg > FIELD_W'(MAX_LIMIT)) ? FIELD_W'(MAX_LIMIT) : limit_reg;
    assign err_in  = (cand_ch.candidate != expected_reg) || (cand_ch.candidate > lim_eff)
                  || (cand_ch.candidate < FIELD_W'(FIRST_CAND));

    // A prime is stored while the list has room.
    assign list_we = ctrl.check & !err_reg & !map_rd_reg
                   & (total_reg != TOTAL_W'(PRIME_SLOTS));

    // Map writes come from the clearing sweep or from marking a product.
    assign map_we = ctrl.clear | ctrl.mark;
    assign map_wa = ctrl.clear ? clr_cnt_reg : prod_reg[MAP_AW-1:0];
    assign map_wd = ctrl.mark;

    assign out_free = !out_valid_reg || result_ch.ready;

    // Next values of the control registers.
    always_comb
    begin
        limit_next     = limit_we ? limit_wdata : limit_reg;
        expected_next  = expected_reg;
        total_next     = total_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        if (ctrl.check && !err_reg)
        begin
            expected_next = cand_reg + FIELD_W'(1);
        end
        if (list_we)
        begin
            total_next = total_reg + TOTAL_W'(1);
        end
        if (ctrl.clear && !status.clr_last)
        begin
            clr_cnt_next = clr_cnt_reg + MAP_AW'(1);
        end
        if (ctrl.emit && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= FIELD_W'(MAX_LIMIT);
            expected_reg  <= FIELD_W'(FIRST_CAND);
            total_reg     <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg     <= limit_next;
            expected_reg  <= expected_next;
            total_reg     <= total_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request capture, walk index, product and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cand_reg <= cand_ch.candidate;
            lim_reg  <= lim_eff;
            err_reg  <= err_in;
        end
        if (ctrl.check)
        begin
            prime_reg <= !err_reg & !map_rd_reg;
            idx_reg   <= '0;
        end
        if (ctrl.advance)
        begin
            idx_reg <= idx_reg + TOTAL_W'(1);
        end
        if (ctrl.mul)
        begin
            prod_reg <= PROD_W'(cand_reg) * PROD_W'(list_rd_reg);
        end
        if (ctrl.emit && out_free)
        begin
            out_number_reg <= cand_reg;
            out_prime_reg  <= prime_reg & !err_reg;
            out_err_reg    <= err_reg;
        end
    end

    // Composite map: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_wa] <= map_wd;
        end
        if (ctrl.take)
        begin
            map_rd_reg <= map_mem[cand_ch.candidate];
        end
    end

    // Prime list: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[total_reg[SLOT_AW-1:0]] <= cand_reg;
        end
        if (ctrl.fetch)
        begin
            list_rd_reg <= list_mem[idx_reg[SLOT_AW-1:0]];
        end
    end

    // Divisibility of the request by the current prime.
    lps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.mul),
        .dividend (cand_reg),
        .divisor  (list_rd_reg),
        .busy     (div_busy),
        .rem_zero (rem_zero)
    );

    // Flags for the sequencer.
    always_comb
    begin
        status.clr_last = (clr_cnt_reg == MAP_AW'(MAP_DEPTH - 1));
        status.req      = cand_ch.valid;
        status.seq_err  = err_reg;
        status.walk_end = (idx_reg >= total_reg);
        status.prod_gt  = (prod_reg > PROD_W'(lim_reg));
        status.div_busy = div_busy;
        status.rem_zero = rem_zero;
        status.out_free = out_free;
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.number         = out_number_reg;
    assign result_ch.prime_flag     = out_prime_reg;
    assign result_ch.sequence_error = out_err_reg;

endmodule

@@ rtl/lps_checker.sv @@
// Port-level checks of the prime sieve and their binding to the top level.
`include "linear_prime_sieve_defines.svh"

module lps_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [lps_pkg::FIELD_W-1:0] number,
    input logic                        prime_flag,
    input logic                        sequence_error
);
    import lps_pkg::*;

    logic [FIELD_W+1:0] payload;
    logic               in_range;

    // Whole result payload and the range of an accepted number.
    assign payload  = {number, prime_flag, sequence_error};
    assign in_range = (number >= FIELD_W'(FIRST_CAND)) && (number <= FIELD_W'(MAX_LIMIT));

    // A stalled result stays offered.
    `LPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

    // A stalled result keeps its payload.
    `LPS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(payload), "result changed")

    // A flagged request is never reported prime.
    `LPS_ASSERT_IMPL(a_flags, out_valid, !(prime_flag && sequence_error), "flagged prime")

    // An accepted candidate lies within the sieve.
    `LPS_ASSERT_IMPL(a_range, out_valid && !sequence_error, in_range, "number out of range")

    // Nothing is offered or taken in the cycle after reset is seen.
    `LPS_ASSERT_NEXT_ALWAYS(a_reset_quiet, !rst_n, !out_valid && !in_ready, "reset activity")

endmodule

bind linear_prime_sieve lps_checker u_lps_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (cand_ch.ready),
    .out_valid      (result_ch.valid),
    .out_ready      (result_ch.ready),
    .number         (result_ch.number),
    .prime_flag     (result_ch.prime_flag),
    .sequence_error (result_ch.sequence_error)
);
